// ===== design/hft_pkg.sv =====
// ----------------------------------------------------------------------------
// hft_pkg
// Shared types and constants for the handshake fragment reassembly tracker.
// ----------------------------------------------------------------------------
package hft_pkg;

  localparam int SEQ_W      = 16;
  localparam int BYTE_W     = 24;
  localparam int CNT_W      = 32;
  localparam int STAT_W     = 3;
  localparam int SMALL_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Item commands.
  localparam logic CMD_FRAG = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] TIMEOUT_RESET = 32'd1000;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK    = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_DUP   = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_OFF   = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_TFULL = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_FFULL = 3'd4;
  localparam logic [STAT_W-1:0] STATUS_TICK  = 3'd5;

  typedef struct packed {
    logic              cmd;
    logic [SEQ_W-1:0]  seq_num;
    logic [BYTE_W-1:0] frag_offset;
    logic [BYTE_W-1:0] frag_length;
    logic [BYTE_W-1:0] message_length;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SEQ_W-1:0]   done_seq;
    logic               msg_done;
    logic               out_of_order;
    logic [SMALL_W-1:0] evicted_count;
    logic [CNT_W-1:0]   fragments_seen;
    logic [CNT_W-1:0]   duplicates_seen;
    logic [CNT_W-1:0]   reorders_seen;
    logic [CNT_W-1:0]   completions_seen;
    logic [CNT_W-1:0]   timeouts_seen;
    logic [SMALL_W-1:0] active_entries;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_LOAD,
    S_CHECK,
    S_WALK,
    S_TICK,
    S_FIN
  } state_e;

endpackage

// ===== design/hft_if.sv =====
// ----------------------------------------------------------------------------
// hft_if
// Valid/ready channels that carry input items and result items.
// ----------------------------------------------------------------------------
interface hft_in_if;
  logic                valid;
  logic                ready;
  hft_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hft_out_if;
  logic                valid;
  logic                ready;
  hft_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/handshake_fragment_reassembly_tracker_top.sv =====
// ----------------------------------------------------------------------------
// handshake_fragment_reassembly_tracker_top
// Tracks reassembly of fragmented handshake messages with a small sequencer.
// ----------------------------------------------------------------------------
// A fragment item finds its entry, loads the entry's stored fragments from
// the fragment memory (one read port), checks and appends, then walks the
// stored fragments over the shared compare/add unit and posts the result.
// A tick checks every entry's age on the shared subtract/compare, then posts.
// One item at a time; the result register frees the input side once loaded.
// Reset clears entry valid bits, counters, clock, and restores the registers.
module handshake_fragment_reassembly_tracker_top #(
  parameter int MAX_MESSAGES  = 8,
  parameter int MAX_FRAGMENTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hft_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hft_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  hft_in_if.sink                           in_i,
  hft_out_if.source                        out_o
);
  import hft_pkg::*;

  localparam int SLOT_W = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam int FIDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int FCNT_W = $clog2(MAX_FRAGMENTS + 1);
  localparam int ECNT_W = $clog2(MAX_MESSAGES + 1);
  localparam int DEPTH  = MAX_MESSAGES * MAX_FRAGMENTS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EXP_W  = BYTE_W + FCNT_W;

  // Control state.
  state_e state_q, state_d;
  logic                  enable_q;
  logic [CNT_W-1:0]      timeout_q;
  logic [CNT_W-1:0]      now_q;
  logic [MAX_MESSAGES-1:0] valid_q;
  logic [ECNT_W-1:0]     active_q;
  logic [CNT_W-1:0]      frag_cnt_q, dup_cnt_q, reord_cnt_q, done_cnt_q, tout_cnt_q;
  logic                  rd_pend_q;
  logic                  out_valid_q;

  // Entry table.
  logic [SEQ_W-1:0]  seq_q    [MAX_MESSAGES];
  logic [BYTE_W-1:0] total_q  [MAX_MESSAGES];
  logic [CNT_W-1:0]  start_q  [MAX_MESSAGES];
  logic [FCNT_W-1:0] fcount_q [MAX_MESSAGES];

  // Fragment memory.
  logic [BYTE_W-1:0] mem_off [DEPTH];
  logic [BYTE_W-1:0] mem_len [DEPTH];
  logic [BYTE_W-1:0] rd_off_q, rd_len_q;
  logic [FIDX_W-1:0] rd_idx_q;

  // Working payload.
  in_item_t          item_q;
  logic [SLOT_W-1:0] slot_q;
  logic [FCNT_W-1:0] n_q, k_q, walked_q;
  logic [BYTE_W-1:0] loc_off_q [MAX_FRAGMENTS];
  logic [BYTE_W-1:0] loc_len_q [MAX_FRAGMENTS];
  logic [MAX_FRAGMENTS-1:0] used_q;
  logic [BYTE_W-1:0] last_off_q;
  logic [EXP_W-1:0]  expect_q;
  logic [SLOT_W-1:0] e_q;
  logic [ECNT_W-1:0] evicted_q;
  logic [STAT_W-1:0] status_q;
  logic              complete_q, ooo_q;
  out_item_t         out_q;

  logic accept, out_free;
  logic hit_any, free_any;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  logic dup_any, any_lt, any_eq;
  logic [BYTE_W-1:0] pick_len;
  logic [FIDX_W-1:0] pick_idx;
  logic [EXP_W-1:0]  expect_nxt;
  logic walk_fail, walk_last, walk_done_ok;
  logic aged;
  logic [ADDR_W-1:0] base_addr;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign base_addr = ADDR_W'(slot_q) * ADDR_W'(MAX_FRAGMENTS);

  // Entry lookup: lowest matching valid entry, else lowest free entry.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int e = MAX_MESSAGES - 1; e >= 0; e--) begin
      if (valid_q[e] && seq_q[e] == item_q.seq_num) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(e);
      end
      if (!valid_q[e]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(e);
      end
    end
  end

  // Duplicate check and coverage walk over the local fragment lanes.
  always_comb begin
    dup_any  = 1'b0;
    any_lt   = 1'b0;
    any_eq   = 1'b0;
    pick_len = '0;
    pick_idx = '0;
    for (int i = MAX_FRAGMENTS - 1; i >= 0; i--) begin
      if (FCNT_W'(i) < n_q) begin
        if (loc_off_q[i] == item_q.frag_offset && loc_len_q[i] == item_q.frag_length) begin
          dup_any = 1'b1;
        end
        if (!used_q[i]) begin
          if ({{FCNT_W{1'b0}}, loc_off_q[i]} < expect_q) begin
            any_lt = 1'b1;
          end
          if ({{FCNT_W{1'b0}}, loc_off_q[i]} == expect_q) begin
            any_eq   = 1'b1;
            pick_len = loc_len_q[i];
            pick_idx = FIDX_W'(i);
          end
        end
      end
    end
  end

  assign expect_nxt   = expect_q + {{FCNT_W{1'b0}}, pick_len};
  assign walk_fail    = any_lt || !any_eq;
  assign walk_last    = (walked_q + FCNT_W'(1)) == n_q;
  assign walk_done_ok = !walk_fail && walk_last &&
                        (expect_nxt == {{FCNT_W{1'b0}}, total_q[slot_q]});
  assign aged = valid_q[e_q] && ((now_q - start_q[e_q]) > timeout_q);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.data.cmd == CMD_TICK) begin
            state_d = S_TICK;
          end else if (!enable_q) begin
            state_d = S_FIN;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (hit_any) begin
          state_d = S_LOAD;
        end else if (free_any) begin
          state_d = S_CHECK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LOAD: begin
        if (k_q == n_q && !rd_pend_q) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dup_any || n_q >= FCNT_W'(MAX_FRAGMENTS)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_fail || walk_last) begin
          state_d = S_FIN;
        end
      end
      S_TICK: begin
        if (e_q == SLOT_W'(MAX_MESSAGES - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, clock, valid bits, counters and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      timeout_q   <= TIMEOUT_RESET;
      now_q       <= '0;
      valid_q     <= '0;
      active_q    <= '0;
      frag_cnt_q  <= '0;
      dup_cnt_q   <= '0;
      reord_cnt_q <= '0;
      done_cnt_q  <= '0;
      tout_cnt_q  <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ENABLE) begin
          enable_q <= cfg_data_i[0];
        end else if (cfg_idx_i == CFG_TIMEOUT && cfg_data_i != '0) begin
          timeout_q <= cfg_data_i;
        end
      end
      rd_pend_q <= (state_q == S_LOAD) && (k_q != n_q);
      // A new result takes the register as soon as the old one is gone.
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.data.cmd == CMD_TICK) begin
              now_q <= now_q + 1'b1;
            end else if (enable_q) begin
              frag_cnt_q <= frag_cnt_q + 1'b1;
            end
          end
        end
        S_FIND: begin
          if (!hit_any && free_any) begin
            valid_q[free_idx] <= 1'b1;
            active_q          <= active_q + 1'b1;
          end
        end
        S_CHECK: begin
          if (dup_any) begin
            dup_cnt_q <= dup_cnt_q + 1'b1;
          end else if (n_q < FCNT_W'(MAX_FRAGMENTS) && n_q != '0 &&
                       item_q.frag_offset < last_off_q) begin
            reord_cnt_q <= reord_cnt_q + 1'b1;
          end
        end
        S_WALK: begin
          if (walk_done_ok) begin
            valid_q[slot_q] <= 1'b0;
            active_q        <= active_q - 1'b1;
            done_cnt_q      <= done_cnt_q + 1'b1;
          end
        end
        S_TICK: begin
          if (aged) begin
            valid_q[e_q] <= 1'b0;
            active_q     <= active_q - 1'b1;
            tout_cnt_q   <= tout_cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Fragment memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CHECK && !dup_any && n_q < FCNT_W'(MAX_FRAGMENTS)) begin
      mem_off[base_addr + ADDR_W'(n_q)] <= item_q.frag_offset;
      mem_len[base_addr + ADDR_W'(n_q)] <= item_q.frag_length;
    end
    if (state_q == S_LOAD && k_q != n_q) begin
      rd_off_q <= mem_off[base_addr + ADDR_W'(k_q)];
      rd_len_q <= mem_len[base_addr + ADDR_W'(k_q)];
      rd_idx_q <= FIDX_W'(k_q);
    end
  end

  // Working payload and entry table fields.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_q     <= in_i.data;
          complete_q <= 1'b0;
          ooo_q      <= 1'b0;
          evicted_q  <= '0;
          e_q        <= '0;
          status_q   <= (in_i.data.cmd == CMD_TICK) ? STATUS_TICK : STATUS_OFF;
        end
      end
      S_FIND: begin
        k_q <= '0;
        if (hit_any) begin
          slot_q <= hit_idx;
          n_q    <= fcount_q[hit_idx];
        end else if (free_any) begin
          slot_q             <= free_idx;
          n_q                <= '0;
          seq_q[free_idx]    <= item_q.seq_num;
          total_q[free_idx]  <= item_q.message_length;
          start_q[free_idx]  <= now_q;
          fcount_q[free_idx] <= '0;
        end else begin
          status_q <= STATUS_TFULL;
        end
      end
      S_LOAD: begin
        if (k_q != n_q) begin
          k_q <= k_q + 1'b1;
        end
        if (rd_pend_q) begin
          loc_off_q[rd_idx_q] <= rd_off_q;
          loc_len_q[rd_idx_q] <= rd_len_q;
          last_off_q          <= rd_off_q;
        end
      end
      S_CHECK: begin
        if (dup_any) begin
          status_q <= STATUS_DUP;
        end else if (n_q >= FCNT_W'(MAX_FRAGMENTS)) begin
          status_q <= STATUS_FFULL;
        end else begin
          status_q                   <= STATUS_OK;
          loc_off_q[FIDX_W'(n_q)]    <= item_q.frag_offset;
          loc_len_q[FIDX_W'(n_q)]    <= item_q.frag_length;
          ooo_q    <= (n_q != '0) && (item_q.frag_offset < last_off_q);
          fcount_q[slot_q] <= n_q + 1'b1;
          n_q      <= n_q + 1'b1;
          used_q   <= '0;
          expect_q <= '0;
          walked_q <= '0;
        end
      end
      S_WALK: begin
        if (!walk_fail) begin
          used_q[pick_idx] <= 1'b1;
          expect_q         <= expect_nxt;
          walked_q         <= walked_q + 1'b1;
        end
        complete_q <= walk_done_ok;
      end
      S_TICK: begin
        e_q <= e_q + 1'b1;
        if (aged) begin
          evicted_q <= evicted_q + 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_q.status           <= status_q;
          out_q.done_seq         <= complete_q ? item_q.seq_num : '0;
          out_q.msg_done         <= complete_q;
          out_q.out_of_order     <= ooo_q;
          out_q.evicted_count    <= SMALL_W'(evicted_q);
          out_q.fragments_seen   <= frag_cnt_q;
          out_q.duplicates_seen  <= dup_cnt_q;
          out_q.reorders_seen    <= reord_cnt_q;
          out_q.completions_seen <= done_cnt_q;
          out_q.timeouts_seen    <= tout_cnt_q;
          out_q.active_entries   <= SMALL_W'(active_q);
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The open entry count never exceeds the table size.
  a_active_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= ECNT_W'(MAX_MESSAGES))
    else $error("active entry count above table size");

  // An accepted item holds off the next one: input ready is low in the cycle after.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input ready right after a transfer");

  // The walk never runs past the stored fragments.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (walked_q < n_q))
    else $error("coverage walk beyond fragment count");

  // A completed message is always reported with accepted status.
  a_complete_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.msg_done) |-> (out_q.status == STATUS_OK))
    else $error("completion with non-accepted status");
`endif

endmodule
